>>> hdl/kshf_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the key scan block with its message queue.
// No dependencies; imported by the top level and by kshf_fifo.
package kshf_pkg;

    localparam int KEY_FIELD_W = 5;
    localparam int KEY_IDX_W = 3;
    localparam int EVENT_W = 2;
    localparam int COUNT_W = 8;
    localparam int MSG_W = KEY_IDX_W + EVENT_W;

    localparam logic [EVENT_W-1:0] EV_DOWN = 2'd0;
    localparam logic [EVENT_W-1:0] EV_HOLD = 2'd1;
    localparam logic [EVENT_W-1:0] EV_UP = 2'd2;

    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_NORMAL = 2'd1;
    localparam logic [1:0] MARK_FULL = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] CFG_CONFIRM = 2'd0;
    localparam logic [1:0] CFG_HOLD = 2'd1;
    localparam logic [1:0] CFG_LEVEL = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic                 push;
        logic [KEY_IDX_W-1:0] push_key;
        logic [EVENT_W-1:0]   push_event;
        logic                 pop;
    } fifo_cmd_t;

endpackage

>>> hdl/key_scan_debounce_hold_fifo.sv
`timescale 1ns / 1ps
// Top level of the key scan block: sequencer, press-count memory, settings.
// Depends on kshf_pkg, kshf_ram and kshf_fifo.
//
// Input words arrive on the s_ channel. s_tuser selects the operation: a scan
// tick, whose s_tdata carries one sampled pin level per key, or a read that
// takes one message from the queue. Every input word yields one output word
// on the m_ channel with the message (if any) and the queue mark.
// A scan tick walks the keys through the press-count memory, one key per
// cycle with the next key's read overlapping the current key's write back,
// and its result is registered once the last key has been written back.
// A read's message comes through the queue memory's registered read port
// before the result is registered; an empty queue skips that step. The
// next word is accepted only after the result reaches the output register.
// One word is worked on at a time. The output register holds a finished word
// until it is taken; a new input word is accepted meanwhile, and the block
// waits only before delivering. Reset empties the queue, clears all press
// counts through per-key valid bits and loads the default settings.
// Settings are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle; the block does not enforce it.
module key_scan_debounce_hold_fifo #(
    parameter int NUM_KEYS = 5,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] key_levels, [7:5] zero
    input  logic       s_tuser,   // [0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [2:0] key_index, [4:3] key_event, [6:5] queue_state
    output logic       m_tuser,   // [0] msg_valid
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import kshf_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KW-1:0] KEY_LAST = KW'(NUM_KEYS - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_READ = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] confirm_reg;
    logic [7:0] hold_reg;
    logic       level_reg;

    logic [KEY_FIELD_W-1:0] levels_reg;
    logic [KW-1:0]          key_reg, key_next;
    logic [NUM_KEYS-1:0]    cnt_vld_reg;
    logic [NUM_KEYS-1:0]    lvl_vec;

    logic                 res_valid_reg;
    logic [KEY_IDX_W-1:0] res_key_reg;
    logic [EVENT_W-1:0]   res_event_reg;

    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;

    logic                 accept, out_free, last_key;
    logic                 cnt_re, cnt_we;
    logic [KW-1:0]        cnt_raddr;
    logic [COUNT_W-1:0]   cnt_rdata, cnt_cur, cnt_inc, cnt_new;
    logic [COUNT_W:0]     conf1, hold1;
    logic                 pressed;
    fifo_cmd_t            fcmd;
    logic [1:0]           mark;
    logic [KEY_IDX_W-1:0] pop_key;
    logic [EVENT_W-1:0]   pop_event;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_KEYS; gi++)
        begin : g_lvl
            if (gi < KEY_FIELD_W)
            begin : g_pin
                assign lvl_vec[gi] = levels_reg[gi];
            end
            else
            begin : g_none
                assign lvl_vec[gi] = 1'b0;
            end
        end
    endgenerate

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign last_key = (key_reg == KEY_LAST);

    // Press-count update and message push for the key whose count arrives this cycle, and the pop for an accepted read.
    always_comb
    begin
        cnt_cur = cnt_vld_reg[key_reg] ? cnt_rdata : '0;
        cnt_inc = (cnt_cur == COUNT_MAX) ? COUNT_MAX : cnt_cur + 1'b1;
        conf1 = {1'b0, confirm_reg} + 1'b1;
        hold1 = {1'b0, hold_reg} + 1'b1;
        pressed = (lvl_vec[key_reg] == level_reg);
        cnt_new = cnt_inc;
        fcmd = '0;
        fcmd.push_key = KEY_IDX_W'(key_reg);
        if (pressed)
        begin
            if ({1'b0, cnt_inc} == conf1)
            begin
                fcmd.push = 1'b1;
                fcmd.push_event = EV_DOWN;
            end
            else if (({1'b0, cnt_inc} > conf1) && ({1'b0, cnt_inc} >= hold1))
            begin
                fcmd.push = 1'b1;
                fcmd.push_event = EV_HOLD;
                cnt_new = conf1[COUNT_W-1:0];
            end
        end
        else
        begin
            cnt_new = '0;
            if (cnt_cur > confirm_reg)
            begin
                fcmd.push = 1'b1;
                fcmd.push_event = EV_UP;
            end
        end
        if (state_reg != ST_SCAN)
        begin
            fcmd.push = 1'b0;
        end
        fcmd.pop = accept && (s_tuser == OP_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        key_next = key_reg;
        cnt_re = 1'b0;
        cnt_raddr = '0;
        cnt_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next = '0;
                    if (s_tuser == OP_TICK)
                    begin
                        cnt_re = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (mark != MARK_EMPTY)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCAN:
            begin
                cnt_we = 1'b1;
                if (last_key)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_re = 1'b1;
                    cnt_raddr = key_reg + 1'b1;
                    key_next = key_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_reg <= '0;
            cnt_vld_reg <= '0;
            confirm_reg <= 8'd1;
            hold_reg <= 8'd50;
            level_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            key_reg <= key_next;
            if (cnt_we)
            begin
                cnt_vld_reg[key_reg] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CONFIRM: confirm_reg <= cfg_data;
                    CFG_HOLD:    hold_reg <= cfg_data;
                    CFG_LEVEL:   level_reg <= cfg_data[0];
                    default:     ;
                endcase
            end
            if ((state_reg == ST_FIN) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= s_tdata[KEY_FIELD_W-1:0];
            res_valid_reg <= 1'b0;
            res_key_reg <= '0;
            res_event_reg <= EV_DOWN;
        end
        else if (state_reg == ST_READ)
        begin
            res_valid_reg <= 1'b1;
            res_key_reg <= pop_key;
            res_event_reg <= pop_event;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            m_tdata_reg <= {1'b0, mark, res_event_reg, res_key_reg};
            m_tuser_reg <= res_valid_reg;
        end
    end

    kshf_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(NUM_KEYS)
    ) u_count (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (key_reg),
        .wdata (cnt_new),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    kshf_fifo #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (fcmd),
        .mark      (mark),
        .pop_key   (pop_key),
        .pop_event (pop_event)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

>>> hdl/kshf_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module kshf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/kshf_fifo.sv
`timescale 1ns / 1ps
// Ring queue of key messages with empty, normal and full marks.
// Depends on kshf_pkg and kshf_ram.
module kshf_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kshf_pkg::fifo_cmd_t           cmd,
    output logic [1:0]                    mark,
    output logic [kshf_pkg::KEY_IDX_W-1:0] pop_key,
    output logic [kshf_pkg::EVENT_W-1:0]   pop_event
);
    import kshf_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);

    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0]    mark_reg, mark_next;
    logic          do_push, do_pop;
    logic [MSG_W-1:0] rd_word;

    assign do_push = cmd.push && (mark_reg != MARK_FULL);
    assign do_pop = cmd.pop && (mark_reg != MARK_EMPTY);

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        mark_next = mark_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            mark_next = (wr_ptr_next == rd_ptr_reg) ? MARK_FULL : MARK_NORMAL;
        end
        else if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            mark_next = (rd_ptr_next == wr_ptr_reg) ? MARK_EMPTY : MARK_NORMAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            mark_reg <= MARK_EMPTY;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            mark_reg <= mark_next;
        end
    end

    kshf_ram #(
        .WIDTH(MSG_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (do_push),
        .waddr (wr_ptr_reg),
        .wdata ({cmd.push_event, cmd.push_key}),
        .re    (do_pop),
        .raddr (rd_ptr_reg),
        .rdata (rd_word)
    );

    assign mark = mark_reg;
    assign pop_key = rd_word[KEY_IDX_W-1:0];
    assign pop_event = rd_word[MSG_W-1:KEY_IDX_W];

endmodule

>>> hdl/kshf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the key scan block, bound to the top level.
// Depends on the ports of key_scan_debounce_hold_fifo only.
module kshf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // A word that waits on a stalled receiver keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

    // The block never accepts input words back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on back-to-back cycles");

    // Without a message the key and event fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[4:0] == 5'd0)
    else $error("key fields set without a message");

    // The queue mark and the event code never carry the unused code, and bit 7 stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[6:5] != 2'd3 && m_tdata[4:3] != 2'd3 && !m_tdata[7])
    else $error("unused code in output word");

endmodule

bind key_scan_debounce_hold_fifo kshf_checker u_kshf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
